// ===== design/rpc_pkg.sv =====
// shared types, constants and arctangent table for the rectangular/polar converter
`default_nettype none

package rpc_pkg;

   localparam int DATA_W     = 16;
   localparam int MAG_IN_W   = DATA_W - 1;
   localparam int GUARD      = 16;
   localparam int ITERATIONS = 16;
   localparam int TABLE_LEN  = 24;
   localparam int ITER_N     = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
   localparam int DP_W       = DATA_W + GUARD + 4;
   localparam int Z_W        = 34;
   localparam int PROD_W     = DATA_W + 34;
   localparam int LATENCY    = ITER_N + 4;

   localparam logic [31:0] GAIN_K = 32'd2608131496;
   localparam logic signed [32:0] GAIN_S = {1'b0, GAIN_K};

   localparam logic signed [PROD_W-1:0] HALF_P =
      {{(PROD_W - GUARD){1'b0}}, 1'b1, {(GUARD - 1){1'b0}}};
   // rounding offset for a product whose operand was negated before scaling
   localparam logic signed [PROD_W-1:0] HALF_P_NEG =
      {{(PROD_W - GUARD + 1){1'b0}}, {(GUARD - 1){1'b1}}};
   localparam logic signed [DP_W-1:0] HALF_D =
      {{(DP_W - GUARD){1'b0}}, 1'b1, {(GUARD - 1){1'b0}}};
   localparam logic signed [DP_W-1:0] OUT_MAX = DP_W'(2 ** (DATA_W - 1) - 1);
   localparam logic signed [DP_W-1:0] OUT_MIN = -OUT_MAX - DP_W'(1);

   localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
   localparam logic [31:0] ANG_ROUND  = 32'd1 << (31 - DATA_W);

   localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic {
      ACT_TO_POLAR = 1'b0,
      ACT_TO_RECT  = 1'b1
   } action_type;

   typedef struct packed {
      action_type               action;
      logic signed [DATA_W-1:0] in_x;
      logic signed [DATA_W-1:0] in_y;
      logic [MAG_IN_W-1:0]      in_mag;
      logic signed [DATA_W-1:0] in_angle;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_x;
      logic signed [DATA_W-1:0] out_y;
      logic [DATA_W-1:0]        out_mag;
      logic signed [DATA_W-1:0] out_angle;
   } rsp_type;

   typedef struct packed {
      req_type                  req;
      logic                     zero;
      logic                     neg;
      logic signed [PROD_W-1:0] px;
      logic signed [PROD_W-1:0] py;
      logic signed [Z_W-1:0]    z;
   } prod_type;

   typedef struct packed {
      req_type                req;
      logic                   zero;
      logic signed [DP_W-1:0] x;
      logic signed [DP_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

endpackage

`default_nettype wire

// ===== design/rpc_prescale.sv =====
// input register, quadrant fold, gain multiply and rounding into the guard format
`default_nettype none

module rpc_prescale (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire rpc_pkg::req_type    in_item,
   output logic                     out_valid,
   output rpc_pkg::cordic_type      out_item
);
   import rpc_pkg::*;

   logic       req_valid_ff;
   req_type    req_ff;
   logic       prod_valid_ff;
   prod_type   prod_ff;
   prod_type   prod_in;
   logic       cor_valid_ff;
   cordic_type cor_ff;
   cordic_type cor_in;

   logic signed [DATA_W:0]   xs;
   logic signed [DATA_W:0]   ys;
   logic signed [PROD_W-1:0] px;
   logic signed [PROD_W-1:0] py;
   logic signed [31:0]       z_rot;
   logic                     flip;
   logic signed [PROD_W-1:0] sx;
   logic signed [PROD_W-1:0] sy;
   logic signed [PROD_W-1:0] sx_sh;
   logic signed [PROD_W-1:0] sy_sh;

   // fold the operand and multiply by the cordic gain
   always_comb begin
      xs    = '0;
      ys    = '0;
      z_rot = '0;
      flip  = 1'b0;
      prod_in      = '0;
      prod_in.req  = req_ff;
      if (req_ff.action == ACT_TO_POLAR) begin
         xs           = {req_ff.in_x[DATA_W-1], req_ff.in_x};
         ys           = {req_ff.in_y[DATA_W-1], req_ff.in_y};
         prod_in.zero = (req_ff.in_x == '0) && (req_ff.in_y == '0);
         if (req_ff.in_x[DATA_W-1]) begin
            xs        = -xs;
            ys        = -ys;
            prod_in.z = {{(Z_W - 32){1'b0}}, HALF_TURN};
         end
      end else begin
         flip  = req_ff.in_angle[DATA_W-1] ^ req_ff.in_angle[DATA_W-2];
         xs    = {2'b00, req_ff.in_mag};
         prod_in.neg = flip;
         if (flip) begin
            xs = -xs;
         end
         z_rot = {req_ff.in_angle[DATA_W-1] ^ flip, req_ff.in_angle[DATA_W-2:0],
                  {(32 - DATA_W){1'b0}}};
         prod_in.z = {{(Z_W - 32){z_rot[31]}}, z_rot};
      end
      px = xs * GAIN_S;
      py = ys * GAIN_S;
      prod_in.px = px;
      prod_in.py = py;
   end

   // round half up to the guard format, a negated start x rounds as if negated after
   always_comb begin
      sx     = prod_ff.px + (prod_ff.neg ? HALF_P_NEG : HALF_P);
      sy     = prod_ff.py + HALF_P;
      sx_sh  = sx >>> GUARD;
      sy_sh  = sy >>> GUARD;
      cor_in      = '0;
      cor_in.req  = prod_ff.req;
      cor_in.zero = prod_ff.zero;
      cor_in.x    = sx_sh[DP_W-1:0];
      cor_in.y    = sy_sh[DP_W-1:0];
      cor_in.z    = prod_ff.z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         cor_valid_ff  <= 1'b0;
      end else begin
         req_valid_ff  <= in_valid;
         prod_valid_ff <= req_valid_ff;
         cor_valid_ff  <= prod_valid_ff;
      end
      req_ff  <= in_item;
      prod_ff <= prod_in;
      cor_ff  <= cor_in;
   end

   assign out_valid = cor_valid_ff;
   assign out_item  = cor_ff;

endmodule

`default_nettype wire

// ===== design/rpc_cordic_pipe.sv =====
// unrolled cordic iterations, one register stage per iteration
`default_nettype none

module rpc_cordic_pipe (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire rpc_pkg::cordic_type  in_item,
   output logic                      out_valid,
   output rpc_pkg::cordic_type       out_item
);
   import rpc_pkg::*;

   cordic_type        src [ITER_N];
   logic [ITER_N-1:0] src_valid;
   cordic_type        stage_q [ITER_N];
   logic [ITER_N-1:0] stage_valid_q;

   for (genvar i = 0; i < ITER_N; i++) begin : g_iter
      logic signed [DP_W-1:0] x_cur;
      logic signed [DP_W-1:0] y_cur;
      logic signed [DP_W-1:0] dx;
      logic signed [DP_W-1:0] dy;
      logic signed [Z_W-1:0]  z_cur;
      logic signed [Z_W-1:0]  da;
      logic                   up;
      cordic_type             stage_in;
      cordic_type             stage_ff;
      logic                   valid_ff;

      if (i == 0) begin : g_first
         assign src[i]       = in_item;
         assign src_valid[i] = in_valid;
      end else begin : g_next
         assign src[i]       = stage_q[i-1];
         assign src_valid[i] = stage_valid_q[i-1];
      end

      always_comb begin
         x_cur = src[i].x;
         y_cur = src[i].y;
         z_cur = src[i].z;
         dx    = y_cur >>> i;
         dy    = x_cur >>> i;
         da    = {{(Z_W - 32){1'b0}}, ATAN_TABLE[i]};
         // vectoring drives y toward zero, rotation drives z toward zero
         if (src[i].req.action == ACT_TO_POLAR) begin
            up = !y_cur[DP_W-1];
         end else begin
            up = z_cur[Z_W-1];
         end
         stage_in = src[i];
         if (up) begin
            stage_in.x = x_cur + dx;
            stage_in.y = y_cur - dy;
            stage_in.z = z_cur + da;
         end else begin
            stage_in.x = x_cur - dx;
            stage_in.y = y_cur + dy;
            stage_in.z = z_cur - da;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= src_valid[i];
         end
         stage_ff <= stage_in;
      end

      assign stage_q[i]       = stage_ff;
      assign stage_valid_q[i] = valid_ff;
   end

   assign out_valid = stage_valid_q[ITER_N-1];
   assign out_item  = stage_q[ITER_N-1];

endmodule

`default_nettype wire

// ===== design/rpc_output.sv =====
// final rounding, saturation and field selection into the result register
`default_nettype none

module rpc_output (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire rpc_pkg::cordic_type  in_item,
   output logic                      out_valid,
   output rpc_pkg::rsp_type          out_item
);
   import rpc_pkg::*;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic signed [DP_W-1:0] x_cur;
   logic signed [DP_W-1:0] y_cur;
   logic [DP_W-1:0]        xc;
   logic [DP_W-1:0]        mag_sum;
   logic [DP_W-1:0]        mag_full;
   logic [DATA_W-1:0]      mag_sat;
   logic [31:0]            ang_sum;
   logic signed [DP_W-1:0] rx;
   logic signed [DP_W-1:0] ry;

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DP_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[DATA_W-1:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      x_cur    = in_item.x;
      y_cur    = in_item.y;
      xc       = x_cur[DP_W-1] ? '0 : x_cur;
      mag_sum  = xc + HALF_D;
      mag_full = mag_sum >> GUARD;
      mag_sat  = (|mag_full[DP_W-1:DATA_W]) ? '1 : mag_full[DATA_W-1:0];
      ang_sum  = in_item.z[31:0] + ANG_ROUND;
      rx       = (x_cur + HALF_D) >>> GUARD;
      ry       = (y_cur + HALF_D) >>> GUARD;
      if (in_item.req.action == ACT_TO_POLAR) begin
         rsp_in.out_x = in_item.req.in_x;
         rsp_in.out_y = in_item.req.in_y;
         if (in_item.zero) begin
            rsp_in.out_mag   = '0;
            rsp_in.out_angle = '0;
         end else begin
            rsp_in.out_mag   = mag_sat;
            rsp_in.out_angle = ang_sum[31:32-DATA_W];
         end
      end else begin
         rsp_in.out_x     = sat_data(rx);
         rsp_in.out_y     = sat_data(ry);
         rsp_in.out_mag   = {1'b0, in_item.req.in_mag};
         rsp_in.out_angle = in_item.req.in_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_ff;

endmodule

`default_nettype wire

// ===== design/rect_polar_converter_top.sv =====
// top level of the pipelined cordic rectangular/polar converter
// a result strobes after its item passes the prescale, iteration and result registers
// throughput: one item per cycle, set by the unrolled cordic with one stage per iteration
// busy is high only during reset; the pipeline never stalls
// reset is synchronous and active high, clears all valid bits and drops items in flight
`default_nettype none

module rect_polar_converter_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rpc_pkg::req_type req_item,
   output logic                  rsp_valid,
   output rpc_pkg::rsp_type      rsp_item
);
   import rpc_pkg::*;

   logic       accept;
   logic       pre_valid;
   cordic_type pre_item;
   logic       iter_valid;
   cordic_type iter_item;

   assign busy   = reset;
   assign accept = start && !busy;

   rpc_prescale u_prescale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_item),
      .out_valid (pre_valid),
      .out_item  (pre_item)
   );

   rpc_cordic_pipe u_cordic_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .in_item   (pre_item),
      .out_valid (iter_valid),
      .out_item  (iter_item)
   );

   rpc_output u_output (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (iter_valid),
      .in_item   (iter_item),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without an item taken at the pipeline latency");

   a_rect_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req_item.action, LATENCY) == ACT_TO_RECT) |->
         (rsp_item.out_angle == $past(req_item.in_angle, LATENCY)) &&
         (rsp_item.out_mag == {1'b0, $past(req_item.in_mag, LATENCY)}))
      else $error("polar fields not passed through");

   a_polar_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req_item.action, LATENCY) == ACT_TO_POLAR) |->
         (rsp_item.out_x == $past(req_item.in_x, LATENCY)) &&
         (rsp_item.out_y == $past(req_item.in_y, LATENCY)))
      else $error("rectangular fields not passed through");

endmodule

`default_nettype wire

// ===== tb/sv/rpc_checker.sv =====
`timescale 1ns / 1ps
// checker for the rectangular/polar converter: predicts each taken item and compares results
module rpc_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire rpc_pkg::req_type req_item,
   input  wire logic             rsp_valid,
   input  wire rpc_pkg::rsp_type rsp_item,
   output int                    errors,
   output int                    pending
);
   import rpc_pkg::*;

   localparam int     STAGES     = 16;
   localparam int     FRAC       = 16;
   localparam longint GAIN       = 64'sd2608131496;
   localparam longint FRAC_HALF  = 64'sd32768;
   localparam int     PRINT_CAP  = 100;

   rsp_type converted_q[$];
   rsp_type want;
   int      results_seen;

   // arctangent of 2^-i as a fraction of a full turn
   function automatic bit [31:0] atan_turn(int i);
      case (i)
         0:  return 32'h20000000;
         1:  return 32'h12E4051E;
         2:  return 32'h09FB385B;
         3:  return 32'h051111D4;
         4:  return 32'h028B0D43;
         5:  return 32'h0145D7E1;
         6:  return 32'h00A2F61E;
         7:  return 32'h00517C55;
         8:  return 32'h0028BE53;
         9:  return 32'h00145F2F;
         10: return 32'h000A2F98;
         11: return 32'h000517CC;
         12: return 32'h00028BE6;
         13: return 32'h000145F3;
         14: return 32'h0000A2FA;
         default: return 32'h0000517D;
      endcase
   endfunction

   // gain compensation rounded into the guard format
   function automatic longint gain_scale(longint v);
      return (v * GAIN + FRAC_HALF) >>> FRAC;
   endfunction

   function automatic rsp_type to_polar(req_type r);
      longint    x;
      longint    y;
      longint    dx;
      longint    dy;
      longint    m;
      bit [31:0] z;
      rsp_type   o;
      int        i;
      x = $signed(r.in_x);
      y = $signed(r.in_y);
      z = 32'h0;
      o.out_x = r.in_x;
      o.out_y = r.in_y;
      o.out_mag = '0;
      o.out_angle = '0;
      if (x != 0 || y != 0) begin
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
         end
         x = gain_scale(x);
         y = gain_scale(y);
         for (i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               z = z + atan_turn(i);
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - atan_turn(i);
            end
         end
         if (x < 0) x = 0;
         m = (x + FRAC_HALF) >>> FRAC;
         if (m > 64'sd65535) m = 64'sd65535;
         o.out_mag = m[15:0];
         z = z + 32'h0000_8000;
         o.out_angle = z[31:16];
      end
      return o;
   endfunction

   function automatic rsp_type to_rect(req_type r);
      longint    x;
      longint    y;
      longint    dx;
      longint    dy;
      longint    zs;
      longint    rx;
      longint    ry;
      bit [31:0] z;
      rsp_type   o;
      int        i;
      x = gain_scale(longint'(r.in_mag));
      y = 0;
      z = {r.in_angle, 16'h0000};
      if (z[31:30] == 2'b01 || z[31:30] == 2'b10) begin
         x = -x;
         z = z ^ 32'h8000_0000;
      end
      zs = $signed(z);
      for (i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (zs >= 0) begin
            x = x - dx;
            y = y + dy;
            zs = zs - longint'(atan_turn(i));
         end else begin
            x = x + dx;
            y = y - dy;
            zs = zs + longint'(atan_turn(i));
         end
      end
      rx = (x + FRAC_HALF) >>> FRAC;
      ry = (y + FRAC_HALF) >>> FRAC;
      if (rx < -64'sd32768) rx = -64'sd32768;
      if (rx > 64'sd32767) rx = 64'sd32767;
      if (ry < -64'sd32768) ry = -64'sd32768;
      if (ry > 64'sd32767) ry = 64'sd32767;
      o.out_x = rx[15:0];
      o.out_y = ry[15:0];
      o.out_mag = {1'b0, r.in_mag};
      o.out_angle = r.in_angle;
      return o;
   endfunction

   task automatic report_error(string msg);
      if (errors < PRINT_CAP) $display("error at %0t ns: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_val);
      if (got !== exp_val)
         report_error($sformatf("result %0d %s is %h, predicted %h",
                                results_seen, name, got, exp_val));
   endtask

   initial begin
      errors = 0;
      pending = 0;
      results_seen = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            if (req_item.action == ACT_TO_POLAR) converted_q.push_back(to_polar(req_item));
            else converted_q.push_back(to_rect(req_item));
         end
         if (rsp_valid === 1'b1) begin
            if (converted_q.size() == 0) begin
               report_error("result strobed with no item outstanding");
            end else begin
               want = converted_q.pop_front();
               check_field("out_x", rsp_item.out_x, want.out_x);
               check_field("out_y", rsp_item.out_y, want.out_y);
               check_field("out_mag", rsp_item.out_mag, want.out_mag);
               check_field("out_angle", rsp_item.out_angle, want.out_angle);
            end
            results_seen++;
         end else if (rsp_valid !== 1'b0) begin
            report_error("result strobe is unknown");
         end
      end
      pending = converted_q.size();
   end

endmodule

// ===== tb/sv/tb_rect_polar_converter_top.sv =====
`timescale 1ns / 1ps
// testbench top for the rectangular/polar converter: bursty item stimulus and verdict
module tb_rect_polar_converter_top;
   import rpc_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 1050;
   localparam int DRAIN_CYCLES = 40;
   localparam int TIMEOUT_NS   = 5_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      errors;
   int      pending;
   int      burst_left = 0;
   req_type item;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rect_polar_converter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   rpc_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .errors    (errors),
      .pending   (pending)
   );

   // extremes, small values near zero, or anything
   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               3: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         1, 2: return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   // item goes out in bursts with random gaps between them
   task automatic send_item(req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      start = 1'b1;
      req_item = r;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
      @(negedge clock);
   endtask

   // a and b land in the fields that the action uses, the rest is random
   task automatic send_directed(action_type act, logic [15:0] a, logic [15:0] b);
      req_type r;
      r.action = act;
      r.in_x = rand_word();
      r.in_y = rand_word();
      r.in_mag = 15'(rand_word());
      r.in_angle = rand_word();
      if (act == ACT_TO_POLAR) begin
         r.in_x = a;
         r.in_y = b;
      end else begin
         r.in_mag = 15'(a);
         r.in_angle = b;
      end
      send_item(r);
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // zero vector, axes, left half plane, angle of exactly pi, largest magnitude
      send_directed(ACT_TO_POLAR, 16'sd0, 16'sd0);
      send_directed(ACT_TO_POLAR, 16'sd32767, 16'sd0);
      send_directed(ACT_TO_POLAR, -16'sd32768, 16'sd0);
      send_directed(ACT_TO_POLAR, 16'sd0, 16'sd32767);
      send_directed(ACT_TO_POLAR, 16'sd0, -16'sd32768);
      send_directed(ACT_TO_POLAR, -16'sd32768, -16'sd32768);
      send_directed(ACT_TO_POLAR, 16'sd32767, 16'sd32767);
      send_directed(ACT_TO_POLAR, -16'sd1, 16'sd0);
      send_directed(ACT_TO_POLAR, -16'sd5, 16'sd3);
      send_directed(ACT_TO_POLAR, 16'sd1, -16'sd1);
      send_directed(ACT_TO_POLAR, -16'sd32768, 16'sd32767);
      send_directed(ACT_TO_POLAR, 16'sd32767, -16'sd32768);

      // quadrant edges, back half angles, saturation at full magnitude
      send_directed(ACT_TO_RECT, 16'd0, 16'sd0);
      send_directed(ACT_TO_RECT, 16'd32767, 16'sd0);
      send_directed(ACT_TO_RECT, 16'd32767, 16'sd16384);
      send_directed(ACT_TO_RECT, 16'd32767, -16'sd32768);
      send_directed(ACT_TO_RECT, 16'd32767, -16'sd16384);
      send_directed(ACT_TO_RECT, 16'd32767, 16'sd16383);
      send_directed(ACT_TO_RECT, 16'd32767, 16'sd8192);
      send_directed(ACT_TO_RECT, 16'd32767, 16'sd24576);
      send_directed(ACT_TO_RECT, 16'd1000, -16'sd16385);
      send_directed(ACT_TO_RECT, 16'd32767, -16'sd24577);
      send_directed(ACT_TO_RECT, 16'd1, 16'sd12345);
      send_directed(ACT_TO_RECT, 16'd32767, 16'sd32767);

      // scaled magnitude exactly half way between codes, back half angles
      send_directed(ACT_TO_RECT, 16'd4096, 16'sd24576);
      send_directed(ACT_TO_RECT, 16'd12288, -16'sd24576);
      send_directed(ACT_TO_RECT, 16'd20480, 16'sd16384);
      send_directed(ACT_TO_RECT, 16'd28672, -16'sd32768);

      repeat (RANDOM_ITEMS) begin
         item.action = ($urandom_range(0, 1) == 1) ? ACT_TO_RECT : ACT_TO_POLAR;
         item.in_x = rand_word();
         item.in_y = rand_word();
         item.in_mag = 15'(rand_word());
         item.in_angle = rand_word();
         send_item(item);
      end
      start = 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== rect_polar_converter_top.f =====
design/rpc_pkg.sv
design/rpc_prescale.sv
design/rpc_cordic_pipe.sv
design/rpc_output.sv
design/rect_polar_converter_top.sv
tb/sv/rpc_checker.sv
tb/sv/tb_rect_polar_converter_top.sv
